[sv/pfs_pkg.sv]
package pfs_pkg;

    localparam int unsigned PctMax    = 100;
    localparam int unsigned RampSteps = 30;
    localparam int unsigned RampFloor = 10;
    localparam int unsigned LowLimit  = 30;
    localparam int unsigned LowGoal   = 31;

    // 8191 = 81*100 + 91, and 477113 = 91 * ceil(2^19 / 100)
    localparam int unsigned DutyWhole = 81;
    localparam int unsigned DutyFrac  = 477113;
    localparam int unsigned FracShift = 19;

    localparam int unsigned OpcodeW  = 3;
    localparam int unsigned PercentW = 7;
    localparam int unsigned DutyW    = 13;
    localparam int unsigned StepW    = 3;
    localparam int unsigned CountW   = 5;
    localparam int unsigned FadeMsW  = 16;
    localparam int unsigned FadeMsReset = 10;

    typedef enum logic [OpcodeW-1:0] {
        OP_TICK     = 3'd0,
        OP_ON       = 3'd1,
        OP_OFF      = 3'd2,
        OP_UPDATE   = 3'd3,
        OP_FADE_ON  = 3'd4,
        OP_FADE_OFF = 3'd5,
        OP_RESUME   = 3'd6,
        OP_NOP      = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_FADE     = 2'd1,
        ACT_SET_FADE = 2'd2
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [DutyW-1:0] fade_duty;
        logic             fading_active;
        logic             last;
    } t_result;

    // results produced by one item, zero to two of them
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    // percent (0..100) to duty, truncating p*8191/100
    function automatic logic [DutyW-1:0] pct_to_duty(input logic [PercentW-1:0] p);
        logic [13:0] whole;
        logic [26:0] frac;
        whole = 14'(p) * 14'(DutyWhole);
        frac  = 27'(p) * 27'(DutyFrac);
        return DutyW'(whole + 14'(frac[26:FracShift]));
    endfunction

    // floor(x / 30) for x in 0..100
    function automatic logic [StepW-1:0] step_of(input logic [PercentW-1:0] x);
        logic [StepW-1:0] s;
        if (x >= PercentW'(3 * RampSteps)) begin
            s = 3'd3;
        end else if (x >= PercentW'(2 * RampSteps)) begin
            s = 3'd2;
        end else if (x >= PercentW'(RampSteps)) begin
            s = 3'd1;
        end else begin
            s = 3'd0;
        end
        return s;
    endfunction

endpackage

[sv/pfs_if.sv]
interface pfs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [pfs_pkg::OpcodeW-1:0]   opcode;
    logic [pfs_pkg::PercentW-1:0]  percent;

    modport source (output valid, output opcode, output percent, input ready);
    modport sink   (input valid, input opcode, input percent, output ready);
endinterface

interface pfs_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [pfs_pkg::DutyW-1:0]   fade_duty;
    logic                        fading_active;
    logic                        last;

    modport source (output valid, output action, output fade_duty,
                    output fading_active, output last, input ready);
    modport sink   (input valid, input action, input fade_duty,
                    input fading_active, input last, output ready);
endinterface

[sv/pfs_engine.sv]
module pfs_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pfs_pkg::OpcodeW-1:0]    i_opcode,
    input  logic [pfs_pkg::PercentW-1:0]   i_percent,
    input  logic                           i_room,
    output logic                           o_push_en,
    output pfs_pkg::t_push                 o_push
);

    logic                          r_in_valid;
    pfs_pkg::t_opcode              r_opcode;
    logic [pfs_pkg::PercentW-1:0]  r_percent;

    logic                          r_ramp_active, n_ramp_active;
    logic                          r_ramp_falling, n_ramp_falling;
    logic [pfs_pkg::PercentW-1:0]  r_goal, n_goal;
    logic [pfs_pkg::PercentW-1:0]  r_level, n_level;
    logic [pfs_pkg::StepW-1:0]     r_step, n_step;
    logic [pfs_pkg::CountW-1:0]    r_count, n_count;
    logic [pfs_pkg::DutyW-1:0]     r_held, n_held;

    logic                          fire;
    logic [pfs_pkg::PercentW-1:0]  p_sat;
    logic [pfs_pkg::PercentW-1:0]  p_goal;
    logic [pfs_pkg::CountW-1:0]    tick_count;
    logic [pfs_pkg::PercentW:0]    rise_sum;
    logic [pfs_pkg::PercentW-1:0]  rise_level;
    logic [pfs_pkg::PercentW-1:0]  fall_level;
    logic [pfs_pkg::PercentW-1:0]  tick_level;
    logic                          tick_done;
    logic [pfs_pkg::DutyW-1:0]     level_duty;
    logic [pfs_pkg::DutyW-1:0]     final_duty;
    logic [pfs_pkg::DutyW-1:0]     cmd_duty;
    pfs_pkg::t_push                push;

    // request holds in the input register until the result queue has room for two
    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_opcode  <= pfs_pkg::t_opcode'(i_opcode);
            r_percent <= i_percent;
        end
    end

    // saturated percent and fade goal
    assign p_sat  = (r_percent > pfs_pkg::PercentW'(pfs_pkg::PctMax))
                    ? pfs_pkg::PercentW'(pfs_pkg::PctMax) : r_percent;
    assign p_goal = (p_sat < pfs_pkg::PercentW'(pfs_pkg::LowLimit))
                    ? pfs_pkg::PercentW'(pfs_pkg::LowGoal) : p_sat;

    // one ramp step
    assign tick_count = r_count + 1'b1;
    assign rise_sum   = {1'b0, r_level} + (pfs_pkg::PercentW + 1)'(r_step);
    assign rise_level = (rise_sum > {1'b0, r_goal}) ? r_goal
                        : rise_sum[pfs_pkg::PercentW-1:0];
    assign fall_level = r_level - pfs_pkg::PercentW'(r_step);

    always_comb begin
        if (!r_ramp_falling) begin
            tick_done  = tick_count >= pfs_pkg::CountW'(pfs_pkg::RampSteps);
            tick_level = tick_done ? r_goal : rise_level;
        end else begin
            tick_done  = (tick_count >= pfs_pkg::CountW'(pfs_pkg::RampSteps))
                         || (fall_level < pfs_pkg::PercentW'(pfs_pkg::RampFloor));
            tick_level = tick_done ? '0 : fall_level;
        end
    end

    assign level_duty = pfs_pkg::pct_to_duty(r_level);
    assign final_duty = pfs_pkg::pct_to_duty(tick_level);
    assign cmd_duty   = pfs_pkg::pct_to_duty(p_sat);

    // per-opcode results and next state
    always_comb begin
        n_ramp_active  = r_ramp_active;
        n_ramp_falling = r_ramp_falling;
        n_goal         = r_goal;
        n_level        = r_level;
        n_step         = r_step;
        n_count        = r_count;
        n_held         = r_held;
        push.num       = 2'd0;
        push.res0      = '{action: pfs_pkg::ACT_FADE, fade_duty: cmd_duty,
                           fading_active: r_ramp_active, last: 1'b1};
        push.res1      = '{action: pfs_pkg::ACT_FADE, fade_duty: final_duty,
                           fading_active: 1'b0, last: 1'b1};
        case (r_opcode)
            pfs_pkg::OP_TICK: begin
                if (r_ramp_active) begin
                    n_count             = tick_count;
                    n_level             = tick_level;
                    push.res0.fade_duty     = level_duty;
                    push.res0.fading_active = 1'b1;
                    push.res0.last          = !tick_done;
                    if (tick_done) begin
                        push.num      = 2'd2;
                        n_held        = final_duty;
                        n_ramp_active = 1'b0;
                    end else begin
                        push.num      = 2'd1;
                        n_held        = level_duty;
                    end
                end
            end
            pfs_pkg::OP_ON: begin
                push.num         = 2'd1;
                push.res0.action = pfs_pkg::ACT_SET_FADE;
            end
            pfs_pkg::OP_OFF: begin
                push.num            = 2'd1;
                push.res0.fade_duty = '0;
            end
            pfs_pkg::OP_UPDATE: begin
                push.num = 2'd1;
            end
            pfs_pkg::OP_FADE_ON: begin
                n_goal         = p_goal;
                n_count        = '0;
                n_ramp_active  = 1'b1;
                n_ramp_falling = 1'b0;
                n_level        = pfs_pkg::PercentW'(pfs_pkg::RampFloor);
                n_step         = pfs_pkg::step_of(
                                     p_goal - pfs_pkg::PercentW'(pfs_pkg::RampFloor));
            end
            pfs_pkg::OP_FADE_OFF: begin
                n_goal         = p_goal;
                n_count        = '0;
                n_ramp_active  = 1'b1;
                n_ramp_falling = 1'b1;
                n_level        = p_goal;
                n_step         = pfs_pkg::step_of(p_goal);
            end
            pfs_pkg::OP_RESUME: begin
                if (r_ramp_active) begin
                    push.num                = 2'd1;
                    push.res0.fade_duty     = r_held;
                    push.res0.fading_active = 1'b1;
                end
            end
            default: begin
                push.num = 2'd0;
            end
        endcase
    end

    // ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_active  <= 1'b0;
            r_ramp_falling <= 1'b0;
            r_goal         <= '0;
            r_level        <= '0;
            r_step         <= '0;
            r_count        <= '0;
            r_held         <= '0;
        end else if (fire) begin
            r_ramp_active  <= n_ramp_active;
            r_ramp_falling <= n_ramp_falling;
            r_goal         <= n_goal;
            r_level        <= n_level;
            r_step         <= n_step;
            r_count        <= n_count;
            r_held         <= n_held;
        end
    end

    assign o_push_en = fire;
    assign o_push    = push;

endmodule

[sv/pfs_out_fifo.sv]
module pfs_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  pfs_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output pfs_pkg::t_result  o_data
);

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);

    pfs_pkg::t_result  r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [PtrW:0]     r_fill;

    logic              pop;
    logic [1:0]        push_num;
    logic [PtrW-1:0]   wr_ptr_1;

    assign push_num = i_push_en ? i_push.num : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    // room for the largest burst of one request
    assign o_room  = r_fill <= (PtrW + 1)'(Depth - 2);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd_ptr];

    // storage writes
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(push_num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + (PtrW + 1)'(push_num) - (PtrW + 1)'(pop);
        end
    end

endmodule

[sv/stepped_pwm_fade_sequencer_core.sv]
// Stepped PWM fade sequencer. Takes brightness commands and ticks on i_cmd and
// sends fade commands for a 13-bit PWM channel on o_res. A command enters an
// input register, its results are worked out combinationally and go to a
// four-entry result queue, so a new request is taken every cycle while the
// queue has room for two results; a result is offered on o_res once in the queue.
// On, off, update, a tick during a ramp and a resume during a ramp give one
// result, the tick that ends a ramp gives two, and fade on, fade off, no-op,
// idle ticks and idle resumes give none. fade_time_ms is written through
// i_cfg_we and i_cfg_wdata and held on o_fade_time_ms for the channel driver;
// the user must write it only while idle, and the block does not enforce this.
module stepped_pwm_fade_sequencer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfs_pkg::FadeMsW-1:0]   i_cfg_wdata,
    output logic [pfs_pkg::FadeMsW-1:0]   o_fade_time_ms,
    pfs_cmd_if.sink                       i_cmd,
    pfs_res_if.source                     o_res
);

    logic [pfs_pkg::FadeMsW-1:0]  r_fade_time_ms;
    logic                         room;
    logic                         push_en;
    pfs_pkg::t_push               push;
    pfs_pkg::t_result             res;

    // fade duration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_time_ms <= pfs_pkg::FadeMsW'(pfs_pkg::FadeMsReset);
        end else if (i_cfg_we) begin
            r_fade_time_ms <= i_cfg_wdata;
        end
    end

    assign o_fade_time_ms = r_fade_time_ms;

    pfs_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .o_ready   (i_cmd.ready),
        .i_opcode  (i_cmd.opcode),
        .i_percent (i_cmd.percent),
        .i_room    (room),
        .o_push_en (push_en),
        .o_push    (push)
    );

    pfs_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (push_en),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_data    (res)
    );

    assign o_res.action        = res.action;
    assign o_res.fade_duty     = res.fade_duty;
    assign o_res.fading_active = res.fading_active;
    assign o_res.last          = res.last;

endmodule
